@@ rtl/core/shr_pal_pkg.sv @@
// package with shared types, constants and helpers of the palette pixel decoder
`default_nettype none
package shr_pal_pkg;

    localparam int PALETTE_COUNT_DEF = 16;
    localparam int ENTRIES           = 16;
    localparam int SEL_W             = 4;
    localparam int IDX_W             = 4;
    localparam int COLOR_W           = 12;
    localparam int NIB_W             = 4;
    localparam int COMP_W            = 8;
    localparam int BYTE_W            = 8;
    localparam int STEP_W            = 2;

    localparam logic FUNC_PAL_WRITE = 1'b0;
    localparam logic FUNC_PIXEL     = 1'b1;

    localparam logic [STEP_W-1:0] FIRST_STEP = 2'd0;
    localparam logic [STEP_W-1:0] LAST_STEP  = 2'd3;

    // 640 mode sub-palette offsets, one per pixel of the byte
    localparam logic [IDX_W-1:0] SUB_OFFS_0 = 4'h8;
    localparam logic [IDX_W-1:0] SUB_OFFS_1 = 4'hC;
    localparam logic [IDX_W-1:0] SUB_OFFS_2 = 4'h0;
    localparam logic [IDX_W-1:0] SUB_OFFS_3 = 4'h4;

    typedef struct packed {
        logic valid;
        logic hold_prev;
        logic last;
    } pix_ctl_t;

    function automatic logic [IDX_W-1:0] pixel_index(
        input logic [STEP_W-1:0] step,
        input logic [BYTE_W-1:0] pix_byte,
        input logic              mode_640
    );
        logic [IDX_W-1:0] idx;
        idx = '0;
        if (!mode_640)
        begin
            idx = step[1] ? pix_byte[3:0] : pix_byte[7:4];
        end
        else
        begin
            case (step)
                2'd0:    idx = SUB_OFFS_0 | {2'b00, pix_byte[7:6]};
                2'd1:    idx = SUB_OFFS_1 | {2'b00, pix_byte[5:4]};
                2'd2:    idx = SUB_OFFS_2 | {2'b00, pix_byte[3:2]};
                default: idx = SUB_OFFS_3 | {2'b00, pix_byte[1:0]};
            endcase
        end
        return idx;
    endfunction

    function automatic logic [COMP_W-1:0] expand_nib(input logic [NIB_W-1:0] nib);
        return {nib, {(COMP_W-NIB_W){1'b0}}};
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/shr_pal_if.sv @@
// channel interfaces for input items and pixel beats
`default_nettype none
interface shr_pal_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [3:0] palette_sel;
    logic [3:0] entry_index;
    logic [11:0] entry_color;
    logic [7:0] screen_byte;
    logic       mode_640;
    logic       fill_mode;

    modport source (
        output valid, func, palette_sel, entry_index, entry_color,
               screen_byte, mode_640, fill_mode,
        input  ready
    );
    modport sink (
        input  valid, func, palette_sel, entry_index, entry_color,
               screen_byte, mode_640, fill_mode,
        output ready
    );
endinterface

interface shr_pal_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;

    modport source (
        output valid, red, green, blue, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, red, green, blue, last_pixel,
        output ready
    );
endinterface
`default_nettype wire

@@ rtl/core/shr_pal_issue.sv @@
// item register and pixel step sequencer issuing palette reads and writes
`default_nettype none
module shr_pal_issue #(
    parameter int PALETTE_COUNT = shr_pal_pkg::PALETTE_COUNT_DEF,
    parameter int AW = $clog2(PALETTE_COUNT * shr_pal_pkg::ENTRIES)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    shr_pal_in_if.sink                         byte_ch,
    input  wire logic                          pipe_ready,
    output shr_pal_pkg::pix_ctl_t              rd_ctl,
    output logic [AW-1:0]                      rd_addr,
    output logic                               wr_en,
    output logic [AW-1:0]                      wr_addr,
    output logic [shr_pal_pkg::COLOR_W-1:0]    wr_data
);

    localparam int PSW = (PALETTE_COUNT > 1) ? $clog2(PALETTE_COUNT) : 1;

    logic [PSW-1:0] sel_wrap [shr_pal_pkg::ENTRIES];

    for (genvar g = 0; g < shr_pal_pkg::ENTRIES; g++)
    begin : g_wrap
        assign sel_wrap[g] = PSW'(g % PALETTE_COUNT);
    end

    logic                               busy_reg, busy_next;
    logic [shr_pal_pkg::STEP_W-1:0]     step_reg, step_next;
    logic                               func_reg;
    logic [PSW-1:0]                     sel_reg;
    logic [shr_pal_pkg::IDX_W-1:0]      entry_reg;
    logic [shr_pal_pkg::COLOR_W-1:0]    color_reg;
    logic [shr_pal_pkg::BYTE_W-1:0]     byte_reg;
    logic                               mode_reg;
    logic                               fill_reg;

    logic                               is_pix;
    logic                               advance;
    logic                               done;
    logic                               accept;
    logic [shr_pal_pkg::IDX_W-1:0]      idx;

    assign is_pix  = busy_reg && (func_reg == shr_pal_pkg::FUNC_PIXEL);
    assign advance = is_pix && pipe_ready;
    assign done    = busy_reg && ((func_reg == shr_pal_pkg::FUNC_PAL_WRITE)
                     || (pipe_ready && (step_reg == shr_pal_pkg::LAST_STEP)));
    assign byte_ch.ready = !busy_reg || done;
    assign accept  = byte_ch.valid && byte_ch.ready;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (done)
        begin
            busy_next = 1'b0;
        end
        if (advance)
        begin
            step_next = step_reg + 1'b1;
        end
        if (accept)
        begin
            busy_next = 1'b1;
            step_next = shr_pal_pkg::FIRST_STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= shr_pal_pkg::FIRST_STEP;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= byte_ch.func;
            sel_reg   <= sel_wrap[byte_ch.palette_sel];
            entry_reg <= byte_ch.entry_index;
            color_reg <= byte_ch.entry_color;
            byte_reg  <= byte_ch.screen_byte;
            mode_reg  <= byte_ch.mode_640;
            fill_reg  <= byte_ch.fill_mode;
        end
    end

    assign idx = shr_pal_pkg::pixel_index(step_reg, byte_reg, mode_reg);

    // 320 mode: odd steps repeat the pixel before, fill repeats on index zero
    assign rd_ctl.valid     = advance;
    assign rd_ctl.hold_prev = !mode_reg && (step_reg[0] || (fill_reg && (idx == '0)));
    assign rd_ctl.last      = (step_reg == shr_pal_pkg::LAST_STEP);
    assign rd_addr          = AW'({sel_reg, idx});

    assign wr_en   = busy_reg && (func_reg == shr_pal_pkg::FUNC_PAL_WRITE);
    assign wr_addr = AW'({sel_reg, entry_reg});
    assign wr_data = color_reg;

endmodule
`default_nettype wire

@@ rtl/core/shr_pal_store.sv @@
// palette memory with registered read and pixel control stage
`default_nettype none
module shr_pal_store #(
    parameter int PALETTE_COUNT = shr_pal_pkg::PALETTE_COUNT_DEF,
    parameter int AW = $clog2(PALETTE_COUNT * shr_pal_pkg::ENTRIES)
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire shr_pal_pkg::pix_ctl_t           rd_ctl,
    input  wire logic [AW-1:0]                   rd_addr,
    input  wire logic                            wr_en,
    input  wire logic [AW-1:0]                   wr_addr,
    input  wire logic [shr_pal_pkg::COLOR_W-1:0] wr_data,
    input  wire logic                            emit_ready,
    output logic                                 pipe_ready,
    output shr_pal_pkg::pix_ctl_t                s1_ctl,
    output logic [shr_pal_pkg::COLOR_W-1:0]      s1_data
);

    localparam int DEPTH = PALETTE_COUNT * shr_pal_pkg::ENTRIES;

    logic [shr_pal_pkg::COLOR_W-1:0] mem [DEPTH];
    logic [shr_pal_pkg::COLOR_W-1:0] rd_data_reg;
    shr_pal_pkg::pix_ctl_t           ctl_reg;

    assign pipe_ready = !ctl_reg.valid || emit_ready;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_ctl.valid)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (pipe_ready)
        begin
            ctl_reg <= rd_ctl;
        end
    end

    assign s1_ctl  = ctl_reg;
    assign s1_data = rd_data_reg;

endmodule
`default_nettype wire

@@ rtl/core/shr_pal_emit.sv @@
// colour fill selection, prior colour register and pixel output register
`default_nettype none
module shr_pal_emit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire shr_pal_pkg::pix_ctl_t           s1_ctl,
    input  wire logic [shr_pal_pkg::COLOR_W-1:0] s1_data,
    output logic                                 emit_ready,
    shr_pal_out_if.source                        pixel_ch
);

    logic                            out_valid_reg, out_valid_next;
    logic [shr_pal_pkg::COLOR_W-1:0] prior_reg;
    logic [shr_pal_pkg::COMP_W-1:0]  red_reg;
    logic [shr_pal_pkg::COMP_W-1:0]  green_reg;
    logic [shr_pal_pkg::COMP_W-1:0]  blue_reg;
    logic                            last_reg;
    logic                            take;
    logic [shr_pal_pkg::COLOR_W-1:0] color;

    assign emit_ready = !out_valid_reg || pixel_ch.ready;
    assign take       = s1_ctl.valid && emit_ready;
    assign color      = s1_ctl.hold_prev ? prior_reg : s1_data;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pixel_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (take)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            prior_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                prior_reg <= color;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            red_reg   <= shr_pal_pkg::expand_nib(color[11:8]);
            green_reg <= shr_pal_pkg::expand_nib(color[7:4]);
            blue_reg  <= shr_pal_pkg::expand_nib(color[3:0]);
            last_reg  <= s1_ctl.last;
        end
    end

    assign pixel_ch.valid      = out_valid_reg;
    assign pixel_ch.red        = red_reg;
    assign pixel_ch.green      = green_reg;
    assign pixel_ch.blue       = blue_reg;
    assign pixel_ch.last_pixel = last_reg;

endmodule
`default_nettype wire

@@ rtl/core/shr_palette_pixel_decoder_unit.sv @@
// top level of the palette pixel decoder: palette writes in, rgb pixel beats out
// A palette-write beat gives no pixel; a screen-byte beat gives four pixel beats, one per
// clock unless the output stalls them. The four lookups share the single read port of the
// palette memory (one lookup per pixel), and the next byte can be accepted as the last
// lookup issues. A byte passes through the item register, then the read data and control
// register, then the output register. The output register lets the next byte enter while
// pixels still wait. The palette memory holds no reset value: decode only entries that
// were written. palette_sel wraps modulo PALETTE_COUNT.
`default_nettype none
module shr_palette_pixel_decoder_unit #(
    parameter int PALETTE_COUNT = shr_pal_pkg::PALETTE_COUNT_DEF
) (
    input wire logic       clk,
    input wire logic       rst_n,
    shr_pal_in_if.sink     byte_ch,
    shr_pal_out_if.source  pixel_ch
);

    localparam int AW = $clog2(PALETTE_COUNT * shr_pal_pkg::ENTRIES);

    shr_pal_pkg::pix_ctl_t           rd_ctl;
    shr_pal_pkg::pix_ctl_t           s1_ctl;
    logic [AW-1:0]                   rd_addr;
    logic [AW-1:0]                   wr_addr;
    logic                            wr_en;
    logic [shr_pal_pkg::COLOR_W-1:0] wr_data;
    logic [shr_pal_pkg::COLOR_W-1:0] s1_data;
    logic                            pipe_ready;
    logic                            emit_ready;

    shr_pal_issue #(
        .PALETTE_COUNT (PALETTE_COUNT),
        .AW            (AW)
    ) u_issue (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .pipe_ready (pipe_ready),
        .rd_ctl     (rd_ctl),
        .rd_addr    (rd_addr),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    shr_pal_store #(
        .PALETTE_COUNT (PALETTE_COUNT),
        .AW            (AW)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_ctl     (rd_ctl),
        .rd_addr    (rd_addr),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .emit_ready (emit_ready),
        .pipe_ready (pipe_ready),
        .s1_ctl     (s1_ctl),
        .s1_data    (s1_data)
    );

    shr_pal_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_ctl     (s1_ctl),
        .s1_data    (s1_data),
        .emit_ready (emit_ready),
        .pixel_ch   (pixel_ch)
    );

endmodule
`default_nettype wire

@@ verif/tb_shr_palette_pixel_decoder_unit.sv @@
// testbench for the palette pixel decoder: directed and random beats against a local predictor
`timescale 1ns / 100ps

module tb_shr_palette_pixel_decoder_unit;

    localparam int PAL_COUNT   = shr_pal_pkg::PALETTE_COUNT_DEF;
    localparam int STORE_SLOTS = PAL_COUNT * shr_pal_pkg::ENTRIES;
    localparam int IDLE_LIMIT  = 1000;
    localparam int ITEM_TARGET = 430;

    typedef struct packed {
        logic [shr_pal_pkg::COMP_W-1:0] red;
        logic [shr_pal_pkg::COMP_W-1:0] green;
        logic [shr_pal_pkg::COMP_W-1:0] blue;
        logic                           last_pixel;
    } pixel_t;

    logic clk;
    logic rst_n;

    shr_pal_in_if  byte_if ();
    shr_pal_out_if pix_if ();

    shr_palette_pixel_decoder_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_ch  (byte_if),
        .pixel_ch (pix_if)
    );

    logic [shr_pal_pkg::COLOR_W-1:0] palette_copy [STORE_SLOTS];
    bit                              entry_set [STORE_SLOTS];
    logic [shr_pal_pkg::COLOR_W-1:0] prior_color;
    pixel_t                          pixels_due [$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int idle_cycles    = 0;
    int rx_hold        = 0;
    int calm_left      = 0;
    bit tx_gaps_on     = 1'b1;
    bit tail_phase     = 1'b0;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic int pal_slot(input logic [shr_pal_pkg::SEL_W-1:0] sel, input int idx);
        return (int'(sel) % PAL_COUNT) * shr_pal_pkg::ENTRIES + idx;
    endfunction

    function automatic void predict_pixels(
        input logic [shr_pal_pkg::SEL_W-1:0]  sel,
        input logic [shr_pal_pkg::BYTE_W-1:0] pix_byte,
        input logic                           m640,
        input logic                           fill
    );
        logic [shr_pal_pkg::COLOR_W-1:0] hue [4];
        pixel_t                          px;
        if (!m640)
        begin
            hue[0] = palette_copy[pal_slot(sel, int'(pix_byte[7:4]))];
            if (fill && pix_byte[7:4] == 4'h0)
                hue[0] = prior_color;
            hue[2] = palette_copy[pal_slot(sel, int'(pix_byte[3:0]))];
            if (fill && pix_byte[3:0] == 4'h0)
                hue[2] = hue[0];
            hue[1] = hue[0];
            hue[3] = hue[2];
        end
        else
        begin
            hue[0] = palette_copy[pal_slot(sel,
                         int'(shr_pal_pkg::SUB_OFFS_0) + int'(pix_byte[7:6]))];
            hue[1] = palette_copy[pal_slot(sel,
                         int'(shr_pal_pkg::SUB_OFFS_1) + int'(pix_byte[5:4]))];
            hue[2] = palette_copy[pal_slot(sel,
                         int'(shr_pal_pkg::SUB_OFFS_2) + int'(pix_byte[3:2]))];
            hue[3] = palette_copy[pal_slot(sel,
                         int'(shr_pal_pkg::SUB_OFFS_3) + int'(pix_byte[1:0]))];
        end
        for (int k = 0; k < 4; k++)
        begin
            px.red        = {hue[k][11:8], 4'h0};
            px.green      = {hue[k][7:4], 4'h0};
            px.blue       = {hue[k][3:0], 4'h0};
            px.last_pixel = (k == 3);
            pixels_due.push_back(px);
        end
        prior_color = hue[3];
    endfunction

    task automatic send_item(
        input logic                            func,
        input logic [shr_pal_pkg::SEL_W-1:0]   sel,
        input logic [shr_pal_pkg::IDX_W-1:0]   idx,
        input logic [shr_pal_pkg::COLOR_W-1:0] color,
        input logic [shr_pal_pkg::BYTE_W-1:0]  pix_byte,
        input logic                            m640,
        input logic                            fill
    );
        if (!tail_phase && tx_gaps_on)
        begin
            if (calm_left > 0)
                calm_left--;
            else if ($urandom_range(0, 9) == 0)
                calm_left = $urandom_range(10, 30);
            else if ($urandom_range(0, 3) == 0)
            begin
                byte_if.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        byte_if.valid       <= 1'b1;
        byte_if.func        <= func;
        byte_if.palette_sel <= sel;
        byte_if.entry_index <= idx;
        byte_if.entry_color <= color;
        byte_if.screen_byte <= pix_byte;
        byte_if.mode_640    <= m640;
        byte_if.fill_mode   <= fill;
        @(posedge clk);
        while (!byte_if.ready)
            @(posedge clk);
        items_sent++;
        if (func == shr_pal_pkg::FUNC_PIXEL)
            predict_pixels(sel, pix_byte, m640, fill);
        else
        begin
            palette_copy[pal_slot(sel, int'(idx))] = color;
            entry_set[pal_slot(sel, int'(idx))]    = 1'b1;
        end
    endtask

    task automatic send_write(
        input logic [shr_pal_pkg::SEL_W-1:0]   sel,
        input logic [shr_pal_pkg::IDX_W-1:0]   idx,
        input logic [shr_pal_pkg::COLOR_W-1:0] color
    );
        send_item(shr_pal_pkg::FUNC_PAL_WRITE, sel, idx, color,
                  shr_pal_pkg::BYTE_W'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // entries a byte looks up are written first so no undefined entry is ever read
    task automatic send_pixel(
        input logic [shr_pal_pkg::SEL_W-1:0]  sel,
        input logic [shr_pal_pkg::BYTE_W-1:0] pix_byte,
        input logic                           m640,
        input logic                           fill
    );
        int need [4];
        int n;
        if (!m640)
        begin
            need[0] = int'(pix_byte[7:4]);
            need[1] = int'(pix_byte[3:0]);
            n = 2;
        end
        else
        begin
            need[0] = int'(shr_pal_pkg::SUB_OFFS_0) + int'(pix_byte[7:6]);
            need[1] = int'(shr_pal_pkg::SUB_OFFS_1) + int'(pix_byte[5:4]);
            need[2] = int'(shr_pal_pkg::SUB_OFFS_2) + int'(pix_byte[3:2]);
            need[3] = int'(shr_pal_pkg::SUB_OFFS_3) + int'(pix_byte[1:0]);
            n = 4;
        end
        for (int i = 0; i < n; i++)
            if (!entry_set[pal_slot(sel, need[i])])
                send_write(sel, shr_pal_pkg::IDX_W'(need[i]),
                           shr_pal_pkg::COLOR_W'($urandom_range(0, 4095)));
        send_item(shr_pal_pkg::FUNC_PIXEL, sel, shr_pal_pkg::IDX_W'($urandom_range(0, 15)),
                  shr_pal_pkg::COLOR_W'($urandom_range(0, 4095)), pix_byte, m640, fill);
    endtask

    task automatic random_item();
        logic [shr_pal_pkg::SEL_W-1:0]  sel;
        logic [shr_pal_pkg::BYTE_W-1:0] pb;
        if ($urandom_range(0, 3) == 0)
            sel = shr_pal_pkg::SEL_W'($urandom_range(0, 15));
        else
            sel = shr_pal_pkg::SEL_W'($urandom_range(0, 3));
        if ($urandom_range(0, 4) == 0)
            send_write(sel, shr_pal_pkg::IDX_W'($urandom_range(0, 15)),
                       shr_pal_pkg::COLOR_W'($urandom_range(0, 4095)));
        else
        begin
            pb = shr_pal_pkg::BYTE_W'($urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0)
                pb[7:4] = 4'h0;
            if ($urandom_range(0, 3) == 0)
                pb[3:0] = 4'h0;
            send_pixel(sel, pb, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_prior_reset();
        send_write(4'hF, 4'h0, 12'h123);
        send_write(4'hF, 4'hF, 12'hFFF);
        send_pixel(4'hF, 8'h0F, 1'b0, 1'b1);
    endtask

    task automatic test_fill_320();
        send_write(4'hF, 4'h9, 12'hA5C);
        send_pixel(4'hF, 8'h90, 1'b0, 1'b1);
        send_pixel(4'hF, 8'h00, 1'b0, 1'b1);
        send_pixel(4'hF, 8'h00, 1'b0, 1'b0);
        send_pixel(4'hF, 8'h09, 1'b0, 1'b1);
    endtask

    task automatic test_mode_640();
        send_pixel(4'hF, 8'hFF, 1'b1, 1'b0);
        send_pixel(4'hF, 8'h00, 1'b1, 1'b1);
        send_pixel(4'hF, 8'hE4, 1'b1, 1'b1);
    endtask

    task automatic test_extremes();
        send_write(4'h0, 4'h0, 12'h000);
        send_write(4'h0, 4'hF, 12'hFFF);
        send_pixel(4'h0, 8'hF0, 1'b0, 1'b0);
        send_pixel(4'h0, 8'h0F, 1'b0, 1'b0);
    endtask

    task automatic test_random(input int upto);
        while (items_sent < upto)
            random_item();
    endtask

    task automatic test_output_stall();
        tx_gaps_on = 1'b0;
        rx_hold = 150;
        repeat (12) random_item();
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_sender_drain();
        repeat (8) random_item();
        byte_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pixels_due.size() != 0);
        repeat (8) random_item();
    endtask

    task automatic test_no_idle_tail(input int upto);
        tail_phase = 1'b1;
        test_random(upto);
    endtask

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && pix_if.valid && pix_if.ready)
        begin
            if (pixels_due.size() == 0)
            begin
                $error("unexpected pixel beat: red %0d green %0d blue %0d last %0d",
                       pix_if.red, pix_if.green, pix_if.blue, pix_if.last_pixel);
                mismatch_count++;
            end
            else
            begin
                want = pixels_due.pop_front();
                if (pix_if.red !== want.red)
                begin
                    $error("red: expected %0d, got %0d", want.red, pix_if.red);
                    mismatch_count++;
                end
                if (pix_if.green !== want.green)
                begin
                    $error("green: expected %0d, got %0d", want.green, pix_if.green);
                    mismatch_count++;
                end
                if (pix_if.blue !== want.blue)
                begin
                    $error("blue: expected %0d, got %0d", want.blue, pix_if.blue);
                    mismatch_count++;
                end
                if (pix_if.last_pixel !== want.last_pixel)
                begin
                    $error("last_pixel: expected %0d, got %0d", want.last_pixel,
                           pix_if.last_pixel);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((byte_if.valid && byte_if.ready) || (pix_if.valid && pix_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // pixel sink: random stall bursts, long calm runs, and a forced hold-off on request
    initial
    begin
        int stall_left;
        int run_left;
        bit rdy;
        stall_left = 0;
        run_left   = 0;
        pix_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold > 0)
            begin
                rdy = 1'b0;
                rx_hold--;
            end
            else if (tail_phase)
                rdy = 1'b1;
            else if (stall_left > 0)
            begin
                rdy = 1'b0;
                stall_left--;
            end
            else if (run_left > 0)
            begin
                rdy = 1'b1;
                run_left--;
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                rdy = 1'b0;
                stall_left = $urandom_range(0, 11);
            end
            else
            begin
                rdy = 1'b1;
                run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(0, 6);
            end
            pix_if.ready <= rdy;
        end
    end

    initial
    begin
        for (int i = 0; i < STORE_SLOTS; i++)
        begin
            palette_copy[i] = '0;
            entry_set[i]    = 1'b0;
        end
        prior_color = '0;
        rst_n <= 1'b0;
        byte_if.valid       <= 1'b0;
        byte_if.func        <= shr_pal_pkg::FUNC_PAL_WRITE;
        byte_if.palette_sel <= '0;
        byte_if.entry_index <= '0;
        byte_if.entry_color <= '0;
        byte_if.screen_byte <= '0;
        byte_if.mode_640    <= 1'b0;
        byte_if.fill_mode   <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_prior_reset();
        test_fill_320();
        test_mode_640();
        test_extremes();
        test_random(200);
        test_output_stall();
        test_random(300);
        test_sender_drain();
        test_random(390);
        test_no_idle_tail(ITEM_TARGET);

        byte_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pixels_due.size() != 0);
        repeat (12) @(posedge clk);
        if (mismatch_count == 0 && pixels_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/shr_pal_pkg.sv
rtl/core/shr_pal_if.sv
rtl/core/shr_pal_issue.sv
rtl/core/shr_pal_store.sv
rtl/core/shr_pal_emit.sv
rtl/core/shr_palette_pixel_decoder_unit.sv
verif/tb_shr_palette_pixel_decoder_unit.sv
